>>> rtl/sacl_pkg.sv
package sacl_pkg;

    // Default sizes of the tag store
    localparam int DEF_MAX_SETS  = 256;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 48;

    // Field and register widths
    localparam int STAMP_W    = 32;
    localparam int WAYS_W     = 4;
    localparam int SIB_W      = 4;
    localparam int OFF_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int WAY_OUT_W  = 3;
    // Widest raw set index: set_index_bits can reach 15
    localparam int SET_RAW_W  = (1 << SIB_W) - 1;
    // offset_bits + set_index_bits stays below 64
    localparam int SHIFT_W    = 6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPLACE_POLICY = 2'd0,
        CFG_WAYS_IN_USE    = 2'd1,
        CFG_SET_INDEX_BITS = 2'd2,
        CFG_OFFSET_BITS    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        t_policy            policy;
        logic [WAYS_W-1:0]  ways_in_use;
        logic [SIB_W-1:0]   set_index_bits;
        logic [OFF_W-1:0]   offset_bits;
    } t_cfg;

    // Reset values
    localparam logic [WAYS_W-1:0]  RST_WAYS  = 4'd1;
    localparam logic [SIB_W-1:0]   RST_SIB   = 4'd0;
    localparam logic [OFF_W-1:0]   RST_OFF   = 5'd6;
    localparam logic [STAMP_W-1:0] RST_COUNT = 32'd1;

endpackage

>>> rtl/sacl_addr_split.sv
module sacl_addr_split #(
    parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
    parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS,
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  sacl_pkg::t_cfg        i_cfg,
    input  logic [ADDR_BITS-1:0]  i_address,
    output logic [SET_W-1:0]      o_set,
    output logic [ADDR_BITS-1:0]  o_tag
);
    import sacl_pkg::*;

    logic [ADDR_BITS-1:0] blk_addr;
    logic [SET_RAW_W-1:0] set_mask;
    logic [SET_RAW_W-1:0] set_raw;
    logic [SHIFT_W-1:0]   tag_shift;

    // Block address, then the set index bits above the offset
    assign blk_addr = i_address >> i_cfg.offset_bits;
    assign set_mask = ~({SET_RAW_W{1'b1}} << i_cfg.set_index_bits);
    assign set_raw  = blk_addr[SET_RAW_W-1:0] & set_mask;

    // Tag is everything above offset and index; shifts past the top give zero
    assign tag_shift = SHIFT_W'(i_cfg.offset_bits) + SHIFT_W'(i_cfg.set_index_bits);
    assign o_tag     = i_address >> tag_shift;

    // Fold the raw index into the sets that exist
    if (MAX_SETS == 1) begin : g_one
        assign o_set = '0;
    end else if ((MAX_SETS & (MAX_SETS - 1)) == 0) begin : g_pow2
        logic [SET_W+SET_RAW_W-1:0] raw_ext;
        assign raw_ext = {{SET_W{1'b0}}, set_raw};
        assign o_set   = raw_ext[SET_W-1:0];
    end else begin : g_reduce
        logic [SET_RAW_W-1:0]       rem;
        logic [SET_W+SET_RAW_W-1:0] rem_ext;
        // Restoring reduction by shifted copies of the set count
        always_comb begin
            rem = set_raw;
            for (int k = SET_RAW_W - 1; k >= 0; k--) begin
                if ((longint'(MAX_SETS) << k) < (longint'(1) << SET_RAW_W)) begin
                    if (rem >= SET_RAW_W'(longint'(MAX_SETS) << k)) begin
                        rem = rem - SET_RAW_W'(longint'(MAX_SETS) << k);
                    end
                end
            end
        end
        assign rem_ext = {{SET_W{1'b0}}, rem};
        assign o_set   = rem_ext[SET_W-1:0];
    end

endmodule

>>> rtl/sacl_tag_store.sv
module sacl_tag_store #(
    parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS,
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // High while the valid bits are being cleared after reset
    output logic                          o_init_busy,
    // Row read, data registered for the next cycle
    input  logic                          i_rd_en,
    input  logic [SET_W-1:0]              i_rd_set,
    output logic [ADDR_BITS-1:0]          o_rd_tags   [MAX_WAYS],
    output logic [sacl_pkg::STAMP_W-1:0]  o_rd_stamps [MAX_WAYS],
    output logic [MAX_WAYS-1:0]           o_rd_valid,
    // Single way update
    input  logic                          i_wr_en,
    input  logic                          i_wr_fill,
    input  logic [SET_W-1:0]              i_wr_set,
    input  logic [WAY_W-1:0]              i_wr_way,
    input  logic [ADDR_BITS-1:0]          i_wr_tag,
    input  logic [sacl_pkg::STAMP_W-1:0]  i_wr_stamp
);
    import sacl_pkg::*;

    logic [ADDR_BITS-1:0] r_tag_mem   [MAX_SETS][MAX_WAYS];
    logic [STAMP_W-1:0]   r_stamp_mem [MAX_SETS][MAX_WAYS];
    logic [MAX_WAYS-1:0]  r_valid_mem [MAX_SETS];

    logic [ADDR_BITS-1:0] r_rd_tags   [MAX_WAYS];
    logic [STAMP_W-1:0]   r_rd_stamps [MAX_WAYS];
    logic [MAX_WAYS-1:0]  r_rd_valid;

    // Clearing pass state
    logic                 r_clr_busy;
    logic [SET_W-1:0]     r_clr_set;

    // Bypass of a write to the row being read in the same cycle
    logic                 r_fwd_fill;
    logic                 r_fwd_stamp;
    logic [WAY_W-1:0]     r_fwd_way;
    logic [ADDR_BITS-1:0] r_fwd_tag;
    logic [STAMP_W-1:0]   r_fwd_stamp_val;
    logic                 same_row;

    assign same_row = (i_rd_set == i_wr_set);

    // Tag and stamp memories: one way written, one row read
    always_ff @(posedge i_clk) begin
        if (i_wr_fill) begin
            r_tag_mem[i_wr_set][i_wr_way] <= i_wr_tag;
        end
        if (i_wr_en) begin
            r_stamp_mem[i_wr_set][i_wr_way] <= i_wr_stamp;
        end
        if (i_rd_en) begin
            r_rd_tags   <= r_tag_mem[i_rd_set];
            r_rd_stamps <= r_stamp_mem[i_rd_set];
        end
    end

    // Clearing pass after reset, one set per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_set  <= '0;
        end else if (r_clr_busy) begin
            r_clr_set <= r_clr_set + SET_W'(1);
            if (r_clr_set == SET_W'(MAX_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_init_busy = r_clr_busy;

    // Valid memory: whole row cleared, single bit set on a fill, one row read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_valid_mem[r_clr_set] <= '0;
        end else if (i_wr_fill) begin
            r_valid_mem[i_wr_set][i_wr_way] <= 1'b1;
        end
        if (i_rd_en) begin
            r_rd_valid <= r_valid_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_fill  <= 1'b0;
            r_fwd_stamp <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_fill  <= i_wr_fill && same_row;
            r_fwd_stamp <= i_wr_en && same_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_way       <= i_wr_way;
            r_fwd_tag       <= i_wr_tag;
            r_fwd_stamp_val <= i_wr_stamp;
        end
    end

    // Merge the bypassed way into the read row
    always_comb begin
        o_rd_valid = r_rd_valid;
        if (r_fwd_fill) begin
            o_rd_valid[r_fwd_way] = 1'b1;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            o_rd_tags[w]   = r_rd_tags[w];
            o_rd_stamps[w] = r_rd_stamps[w];
            if (r_fwd_way == WAY_W'(w)) begin
                if (r_fwd_fill) begin
                    o_rd_tags[w] = r_fwd_tag;
                end
                if (r_fwd_stamp) begin
                    o_rd_stamps[w] = r_fwd_stamp_val;
                end
            end
        end
    end

endmodule

>>> rtl/sacl_way_select.sv
module sacl_way_select #(
    parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS,
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  sacl_pkg::t_cfg                i_cfg,
    input  logic [ADDR_BITS-1:0]          i_tag,
    input  logic [ADDR_BITS-1:0]          i_tags   [MAX_WAYS],
    input  logic [sacl_pkg::STAMP_W-1:0]  i_stamps [MAX_WAYS],
    input  logic [MAX_WAYS-1:0]           i_valid,
    output logic                          o_hit,
    output logic [WAY_W-1:0]              o_pick
);
    import sacl_pkg::*;

    localparam int LVLS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int LEAF = 1 << LVLS;

    logic [7:0]          ways_eff;
    logic [MAX_WAYS-1:0] way_en;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] free;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;

    // Oldest-stamp tournament, lower way wins ties
    logic               nd_act   [LVLS+1][LEAF];
    logic [STAMP_W-1:0] nd_stamp [LVLS+1][LEAF];
    logic [WAY_W-1:0]   nd_way   [LVLS+1][LEAF];

    // Ways in use: zero acts as one, clipped to the store
    always_comb begin
        ways_eff = 8'(i_cfg.ways_in_use);
        if (ways_eff == 8'd0) begin
            ways_eff = 8'd1;
        end
        if (ways_eff > 8'(MAX_WAYS)) begin
            ways_eff = 8'(MAX_WAYS);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_en[w] = 8'(w) < ways_eff;
        end
    end

    // Parallel tag compare on valid ways
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            match[w] = way_en[w] && i_valid[w] && (i_tags[w] == i_tag);
            free[w]  = way_en[w] && !i_valid[w];
        end
    end

    // First matching and first free way
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LEAF; i++) begin
            if (i < MAX_WAYS) begin
                nd_act[0][i]   = way_en[i];
                nd_stamp[0][i] = i_stamps[i];
            end else begin
                nd_act[0][i]   = 1'b0;
                nd_stamp[0][i] = '0;
            end
            nd_way[0][i] = WAY_W'(i);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < LEAF; j++) begin
                nd_act[l+1][j]   = 1'b0;
                nd_stamp[l+1][j] = '0;
                nd_way[l+1][j]   = '0;
                if (j < (LEAF >> (l + 1))) begin
                    if (nd_act[l][2*j+1] && (!nd_act[l][2*j] ||
                        nd_stamp[l][2*j+1] < nd_stamp[l][2*j])) begin
                        nd_act[l+1][j]   = 1'b1;
                        nd_stamp[l+1][j] = nd_stamp[l][2*j+1];
                        nd_way[l+1][j]   = nd_way[l][2*j+1];
                    end else begin
                        nd_act[l+1][j]   = nd_act[l][2*j];
                        nd_stamp[l+1][j] = nd_stamp[l][2*j];
                        nd_way[l+1][j]   = nd_way[l][2*j];
                    end
                end
            end
        end
    end

    // Hit way, else first free way, else oldest
    always_comb begin
        o_hit = |match;
        if (|match) begin
            o_pick = hit_way;
        end else if (|free) begin
            o_pick = free_way;
        end else begin
            o_pick = nd_way[LVLS][0];
        end
    end

endmodule

>>> rtl/set_assoc_cache_lookup.sv
// Set-associative cache tag store lookup, write-through and write-allocate.
// Request channel (i_valid/o_ready) carries i_func (0 read, 1 write) and the
// byte address; result channel (o_valid/i_ready) returns hit, mem_read (any
// miss), mem_write (any write) and the way that hit or was filled.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
// must write it only while no request is in flight; the block does not enforce this.
// A request goes through the lookup stage, then the result register. One
// request is taken per cycle while the receiver keeps up; the set row is read
// from the tag/stamp memory at acceptance and updated as the lookup retires,
// with a bypass so that back-to-back requests to the same set see the update.
// Reset sets the access counter to one and loads the default configuration,
// then a clearing pass zeroes the valid bits one set per cycle, and o_ready
// stays low until the pass ends.
// When the receiver stalls, the result register holds; one more request
// moves into the lookup stage, after which o_ready drops until the result
// is taken.
module set_assoc_cache_lookup #(
    parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic [ADDR_BITS-1:0]              i_address,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic                              o_mem_read,
    output logic                              o_mem_write,
    output logic [sacl_pkg::WAY_OUT_W-1:0]    o_way_used
);
    import sacl_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    t_cfg                 r_cfg;
    logic                 in_acc;
    logic                 lk_adv;
    logic                 store_busy;

    logic [SET_W-1:0]     split_set;
    logic [ADDR_BITS-1:0] split_tag;

    // Lookup stage
    logic                 r_lk_vld;
    logic                 r_lk_func;
    logic [SET_W-1:0]     r_lk_set;
    logic [ADDR_BITS-1:0] r_lk_tag;
    logic [STAMP_W-1:0]   r_count;

    logic [ADDR_BITS-1:0] lk_tags   [MAX_WAYS];
    logic [STAMP_W-1:0]   lk_stamps [MAX_WAYS];
    logic [MAX_WAYS-1:0]  lk_valid;
    logic                 sel_hit;
    logic [WAY_W-1:0]     sel_pick;
    logic                 wr_en;
    logic                 wr_fill;
    logic [WAY_W+WAY_OUT_W-1:0] pick_ext;

    // Result register
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic                 r_out_write;
    logic [WAY_OUT_W-1:0] r_out_way;

    // Handshakes
    assign lk_adv  = r_lk_vld && (!r_out_vld || i_ready);
    assign o_ready = !store_busy && (!r_lk_vld || lk_adv);
    assign in_acc  = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy         <= POLICY_FIFO;
            r_cfg.ways_in_use    <= RST_WAYS;
            r_cfg.set_index_bits <= RST_SIB;
            r_cfg.offset_bits    <= RST_OFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REPLACE_POLICY: r_cfg.policy         <= t_policy'(i_cfg_data[0]);
                CFG_WAYS_IN_USE:    r_cfg.ways_in_use    <= i_cfg_data[WAYS_W-1:0];
                CFG_SET_INDEX_BITS: r_cfg.set_index_bits <= i_cfg_data[SIB_W-1:0];
                CFG_OFFSET_BITS:    r_cfg.offset_bits    <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Address split on the incoming request
    sacl_addr_split #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_split (
        .i_cfg     (r_cfg),
        .i_address (i_address),
        .o_set     (split_set),
        .o_tag     (split_tag)
    );

    // Row store, read at acceptance, written as the lookup retires
    assign wr_fill = lk_adv && !sel_hit;
    assign wr_en   = lk_adv && (!sel_hit || (r_cfg.policy == POLICY_LRU));

    sacl_tag_store #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_busy (store_busy),
        .i_rd_en     (in_acc),
        .i_rd_set    (split_set),
        .o_rd_tags   (lk_tags),
        .o_rd_stamps (lk_stamps),
        .o_rd_valid  (lk_valid),
        .i_wr_en     (wr_en),
        .i_wr_fill   (wr_fill),
        .i_wr_set    (r_lk_set),
        .i_wr_way    (sel_pick),
        .i_wr_tag    (r_lk_tag),
        .i_wr_stamp  (r_count)
    );

    // Hit detect and victim choice
    sacl_way_select #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_select (
        .i_cfg    (r_cfg),
        .i_tag    (r_lk_tag),
        .i_tags   (lk_tags),
        .i_stamps (lk_stamps),
        .i_valid  (lk_valid),
        .o_hit    (sel_hit),
        .o_pick   (sel_pick)
    );

    // Lookup stage and access counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_vld <= 1'b0;
            r_count  <= RST_COUNT;
        end else begin
            if (in_acc) begin
                r_lk_vld <= 1'b1;
            end else if (lk_adv) begin
                r_lk_vld <= 1'b0;
            end
            if (lk_adv) begin
                r_count <= r_count + STAMP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lk_func <= i_func;
            r_lk_set  <= split_set;
            r_lk_tag  <= split_tag;
        end
    end

    // Result register
    assign pick_ext = {{WAY_OUT_W{1'b0}}, sel_pick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (lk_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_adv) begin
            r_out_hit   <= sel_hit;
            r_out_write <= r_lk_func;
            r_out_way   <= pick_ext[WAY_OUT_W-1:0];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hit       = r_out_hit;
    assign o_mem_read  = !r_out_hit;
    assign o_mem_write = r_out_write;
    assign o_way_used  = r_out_way;

`ifndef SYNTH
    // A fill followed at once by a request to the same set must see the way valid
    a_fill_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && wr_fill && (split_set == r_lk_set)) |=> lk_valid[$past(sel_pick)])
        else $error("fill not bypassed to next lookup of same set");

    // A stalled lookup keeps its request
    a_lk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lk_vld && !lk_adv) |=> (r_lk_vld && $stable(r_lk_set) && $stable(r_lk_tag)))
        else $error("lookup stage lost its request while stalled");

    // Counter advances exactly once per retired lookup
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lk_vld && lk_adv) |=> (r_count == $past(r_count) + STAMP_W'(1)) && r_out_vld)
        else $error("access count out of step with results");

    // A hit always names an enabled way, which must have been valid
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lk_vld && sel_hit) |-> lk_valid[sel_pick])
        else $error("hit reported on an invalid way");
`endif

endmodule
